### rtl/tcp_connection_table_defines.svh
// Assertion macros shared by the checker of the TCP connection table.
// No dependencies; the including module must provide clk and rst.
`ifndef TCP_CONNECTION_TABLE_DEFINES_SVH
`define TCP_CONNECTION_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TCPCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcp connection table check failed");

// Next-cycle implication, disabled while reset is high.
`define TCPCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcp connection table check failed");

`endif

### rtl/tcpct_pkg.sv
// Shared types and constants of the TCP connection table.
// No dependencies; used by every module of the block.
`default_nettype none

package tcpct_pkg;

  localparam int CONN_SLOTS = 64;
  localparam int SLOT_W     = $clog2(CONN_SLOTS);
  localparam int FUNC_W     = 2;
  localparam int IP_W       = 32;
  localparam int PORT_W     = 16;
  localparam int HANDLE_W   = 6;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 6;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_OPEN   = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_CLOSE  = 2'd2,
    FUNC_DROP   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 3'd0,
    STATUS_EXISTS     = 3'd1,
    STATUS_FULL       = 3'd2,
    STATUS_NOT_FOUND  = 3'd3,
    STATUS_DROPPED    = 3'd4,
    STATUS_BAD_HANDLE = 3'd5
  } status_t;

  typedef struct packed {
    logic [IP_W-1:0]   src_ip;
    logic [IP_W-1:0]   dst_ip;
    logic [PORT_W-1:0] src_port;
    logic [PORT_W-1:0] dst_port;
  } tuple_t;

  // Update command to one cell.
  typedef struct packed {
    logic load;       // store the key, mark live
    logic clear;      // free the slot
    logic mark_drop;  // mark the connection dropped
  } cell_cmd_t;

  typedef enum logic {
    STATE_IDLE = 1'b0,
    STATE_EXEC = 1'b1
  } state_t;

endpackage

`default_nettype wire

### rtl/tcpct_cell.sv
// One slot of the TCP connection table: stored key, flags and the key compare.
// Depends on tcpct_pkg.
`default_nettype none

module tcpct_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmp_en,
  input  tcpct_pkg::tuple_t    key,
  input  tcpct_pkg::cell_cmd_t cmd,
  output logic                 hit_fwd,
  output logic                 hit_rev,
  output logic                 valid,
  output logic                 dropped
);
  import tcpct_pkg::*;

  tuple_t stored;
  logic   eq_fwd;
  logic   eq_rev;

  assign eq_fwd = (stored == key);
  assign eq_rev = (stored.src_ip == key.dst_ip) && (stored.dst_ip == key.src_ip) &&
                  (stored.src_port == key.dst_port) && (stored.dst_port == key.src_port);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      dropped <= 1'b0;
      hit_fwd <= 1'b0;
      hit_rev <= 1'b0;
    end else begin
      if (cmp_en) begin
        hit_fwd <= valid && eq_fwd;
        hit_rev <= valid && eq_rev;
      end
      if (cmd.load) begin
        valid   <= 1'b1;
        dropped <= 1'b0;
      end else if (cmd.clear) begin
        valid   <= 1'b0;
        dropped <= 1'b0;
      end else if (cmd.mark_drop) begin
        dropped <= 1'b1;
      end
    end
  end

  // The key itself needs no reset: it is only compared while the slot is live.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stored <= key;
    end
  end

endmodule

`default_nettype wire

### rtl/tcpct_pick.sv
// Find-first encoder over the slot row: lowest set flag and its index.
// Depends on tcpct_pkg.
`default_nettype none

module tcpct_pick (
  input  logic [tcpct_pkg::CONN_SLOTS-1:0] flags,
  output logic                             found,
  output logic [tcpct_pkg::SLOT_W-1:0]     idx
);
  import tcpct_pkg::*;

  always_comb begin
    found = |flags;
    idx   = '0;
    for (int i = CONN_SLOTS - 1; i >= 0; i--) begin
      if (flags[i]) begin
        idx = SLOT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/tcp_connection_table.sv
// Top level of the TCP connection table: request control, slot row and result register.
// Depends on tcpct_pkg, tcpct_cell and tcpct_pick.
//
// Usage. A request is taken at a rising edge where start is high and busy is
// low; func selects open, lookup, close or drop, the four-tuple serves open
// and lookup, handle serves close and drop. Every request gives exactly one
// result, shown on status, slot, forward and was_dropped for the single
// cycle in which done is high. The receiver cannot hold a result off.
// Timing: in the cycle of acceptance every cell compares its stored key with
// the request in both orientations and registers the outcome. In the next
// cycle (busy high) the find-first encoders pick the matching and the lowest
// free slot, the chosen cell is updated and the result is registered; done
// rises in the cycle after, in which a new request may already be accepted.
// A request therefore passes through the registered compare in the cells,
// followed by the decision and update, before its result is registered.
// Reset (rst, synchronous) empties every slot at once and returns to idle.
`default_nettype none

module tcp_connection_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [tcpct_pkg::FUNC_W-1:0]     func,
  input  logic [tcpct_pkg::IP_W-1:0]       src_ip,
  input  logic [tcpct_pkg::IP_W-1:0]       dst_ip,
  input  logic [tcpct_pkg::PORT_W-1:0]     src_port,
  input  logic [tcpct_pkg::PORT_W-1:0]     dst_port,
  input  logic [tcpct_pkg::HANDLE_W-1:0]   handle,
  output logic                             done,
  output logic [tcpct_pkg::STATUS_W-1:0]   status,
  output logic [tcpct_pkg::SLOT_OUT_W-1:0] slot,
  output logic                             forward,
  output logic                             was_dropped
);
  import tcpct_pkg::*;

  state_t state;
  state_t state_next;
  logic   exec;
  logic   accept;

  // Request held for the decision cycle.
  func_t                func_q;
  tuple_t               key_q;
  logic [HANDLE_W-1:0]  handle_q;

  tuple_t               key_in;
  tuple_t               key_cells;

  // Row state seen by the decision logic.
  logic [CONN_SLOTS-1:0] hit_fwd_v;
  logic [CONN_SLOTS-1:0] hit_rev_v;
  logic [CONN_SLOTS-1:0] valid_v;
  logic [CONN_SLOTS-1:0] dropped_v;
  logic [CONN_SLOTS-1:0] hit_v;
  logic [CONN_SLOTS-1:0] free_v;

  logic                  hit_found;
  logic [SLOT_W-1:0]     hit_idx;
  logic                  free_found;
  logic [SLOT_W-1:0]     free_idx;

  logic                  h_ok;
  logic [SLOT_W-1:0]     h_idx;

  // Decision outputs.
  status_t               res_status;
  logic [SLOT_OUT_W-1:0] res_slot;
  logic                  res_dir;
  logic                  res_drp;
  logic                  wr_load;
  logic                  wr_clear;
  logic                  wr_drop;
  logic [SLOT_W-1:0]     w_idx;

  // ---------------------------------------------------------------------------
  // Control: a request is taken in idle and decided in the following cycle.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      STATE_IDLE: begin
        if (start) begin
          state_next = STATE_EXEC;
        end
      end
      STATE_EXEC: begin
        state_next = STATE_IDLE;
      end
      default: begin
        state_next = STATE_IDLE;
      end
    endcase
  end

  always_comb begin
    busy = 1'b0;
    exec = 1'b0;
    unique case (state)
      STATE_IDLE: begin
        busy = 1'b0;
        exec = 1'b0;
      end
      STATE_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
        exec = 1'b0;
      end
    endcase
  end

  assign accept = start && !busy;

  assign key_in = '{src_ip: src_ip, dst_ip: dst_ip, src_port: src_port, dst_port: dst_port};

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q   <= func_t'(func);
      key_q    <= key_in;
      handle_q <= handle;
    end
  end

  // The cells compare against the live ports while accepting and load the held
  // key while an open is being written back.
  assign key_cells = exec ? key_q : key_in;

  // ---------------------------------------------------------------------------
  // The row of slot cells.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < CONN_SLOTS; i++) begin : g_cell
    cell_cmd_t cmd;

    assign cmd.load      = wr_load  && (w_idx == SLOT_W'(i));
    assign cmd.clear     = wr_clear && (w_idx == SLOT_W'(i));
    assign cmd.mark_drop = wr_drop  && (w_idx == SLOT_W'(i));

    tcpct_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmp_en  (accept),
      .key     (key_cells),
      .cmd     (cmd),
      .hit_fwd (hit_fwd_v[i]),
      .hit_rev (hit_rev_v[i]),
      .valid   (valid_v[i]),
      .dropped (dropped_v[i])
    );
  end

  assign hit_v  = hit_fwd_v | hit_rev_v;
  assign free_v = ~valid_v;

  tcpct_pick u_pick_hit (
    .flags (hit_v),
    .found (hit_found),
    .idx   (hit_idx)
  );

  tcpct_pick u_pick_free (
    .flags (free_v),
    .found (free_found),
    .idx   (free_idx)
  );

  // A handle addresses a slot only when it lies below the table size.
  assign h_ok  = (32'(handle_q) < 32'(CONN_SLOTS));
  assign h_idx = SLOT_W'(handle_q);

  // ---------------------------------------------------------------------------
  // Decision. A slot whose key matches forwards and reversed (a symmetric
  // tuple) counts as forward. An open that meets a dropped entry reuses it.
  // ---------------------------------------------------------------------------
  always_comb begin
    res_status = STATUS_OK;
    res_slot   = '0;
    res_dir    = 1'b0;
    res_drp    = 1'b0;
    wr_load    = 1'b0;
    wr_clear   = 1'b0;
    wr_drop    = 1'b0;
    w_idx      = '0;
    if (exec) begin
      unique case (func_q)
        FUNC_OPEN: begin
          if (hit_found && !dropped_v[hit_idx]) begin
            res_status = STATUS_EXISTS;
            res_slot   = SLOT_OUT_W'(hit_idx);
            res_dir    = hit_fwd_v[hit_idx];
          end else if (hit_found) begin
            wr_load  = 1'b1;
            w_idx    = hit_idx;
            res_slot = SLOT_OUT_W'(hit_idx);
            res_dir  = 1'b1;
          end else if (free_found) begin
            wr_load  = 1'b1;
            w_idx    = free_idx;
            res_slot = SLOT_OUT_W'(free_idx);
            res_dir  = 1'b1;
          end else begin
            res_status = STATUS_FULL;
          end
        end
        FUNC_LOOKUP: begin
          if (!hit_found) begin
            res_status = STATUS_NOT_FOUND;
          end else begin
            res_slot = SLOT_OUT_W'(hit_idx);
            res_dir  = hit_fwd_v[hit_idx];
            if (dropped_v[hit_idx]) begin
              res_status = STATUS_DROPPED;
              res_drp    = 1'b1;
            end
          end
        end
        FUNC_CLOSE, FUNC_DROP: begin
          res_slot = SLOT_OUT_W'(handle_q);
          if (!h_ok || !valid_v[h_idx]) begin
            res_status = STATUS_BAD_HANDLE;
          end else begin
            w_idx    = h_idx;
            wr_clear = (func_q == FUNC_CLOSE);
            wr_drop  = (func_q == FUNC_DROP);
          end
        end
        default: begin
          res_status = STATUS_OK;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: one cycle of done per request.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      status      <= res_status;
      slot        <= res_slot;
      forward     <= res_dir;
      was_dropped <= res_drp;
    end
  end

endmodule

`default_nettype wire

### rtl/tcpct_checker.sv
// Port-level checker of the TCP connection table, bound to the top level.
// Depends on tcpct_pkg and tcp_connection_table_defines.svh.
`default_nettype none

`include "tcp_connection_table_defines.svh"

module tcpct_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             done,
  input logic [tcpct_pkg::STATUS_W-1:0]   status,
  input logic [tcpct_pkg::SLOT_OUT_W-1:0] slot,
  input logic                             forward,
  input logic                             was_dropped
);
  import tcpct_pkg::*;

  // An accepted request keeps the block busy for the decision cycle.
  `TCPCT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // Every busy cycle is followed by exactly one result.
  `TCPCT_ASSERT_NEXT(a_busy_done, busy, done && !busy)
  // A full table reports slot zero and no direction.
  `TCPCT_ASSERT_NOW(a_full_fields, done && (status == STATUS_FULL), (slot == '0) && !forward)
  // The dropped mark appears only with the dropped status.
  `TCPCT_ASSERT_NOW(a_drop_mark, done && was_dropped, status == STATUS_DROPPED)

endmodule

bind tcp_connection_table tcpct_checker u_tcpct_checker (.*);

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for tcp_connection_table: directed requests, then four
// weighted random phases. Depends only on tcpct_pkg and the tcp_connection_table RTL.
`timescale 1ns / 100ps

module testbench;

  import tcpct_pkg::*;

  // No gap that the bench leaves between requests comes up to this limit; nothing should sit idle this long.
  localparam int IDLE_LIMIT  = 1000;
  localparam int PHASE_ITEMS = 490;
  localparam int POOL_DEPTH  = 96;

  // One reply of the table, as the ledger expects it.
  typedef struct {
    status_t                 status;
    logic [SLOT_OUT_W-1:0]   slot;
    logic                    dir_in;
    logic                    dropped;
  } conn_reply_t;

  // The ledger keeps its own copy of the connection table. It works out the
  // reply to every accepted request and checks the replies in order.
  class conn_ledger;
    bit          slot_live    [CONN_SLOTS];
    bit          slot_dropped [CONN_SLOTS];
    tuple_t      slot_key     [CONN_SLOTS];
    conn_reply_t expected_replies[$];
    int          errors;
    int          requests;
    int          status_seen  [6];

    static function tuple_t swap_ends(tuple_t t);
      swap_ends = {t.dst_ip, t.src_ip, t.dst_port, t.src_port};
    endfunction

    function void note_request(func_t op, tuple_t pkt, logic [HANDLE_W-1:0] hdl);
      conn_reply_t r;
      tuple_t      rev;
      int          hit;
      bit          fwd;
      r.status  = STATUS_OK;
      r.slot    = '0;
      r.dir_in  = 1'b0;
      r.dropped = 1'b0;
      rev       = swap_ends(pkt);
      hit       = -1;
      fwd       = 1'b0;
      requests++;
      if (op == FUNC_OPEN || op == FUNC_LOOKUP) begin
        // Within a slot forward orientation wins over reversed; lowest slot wins overall.
        for (int i = 0; i < CONN_SLOTS && hit < 0; i++) begin
          if (slot_live[i]) begin
            if (slot_key[i] == pkt) begin
              hit = i;
              fwd = 1'b1;
            end else if (slot_key[i] == rev) begin
              hit = i;
            end
          end
        end
      end
      case (op)
        FUNC_LOOKUP: begin
          if (hit < 0) begin
            r.status = STATUS_NOT_FOUND;
          end else begin
            r.slot   = hit[SLOT_OUT_W-1:0];
            r.dir_in = fwd;
            if (slot_dropped[hit]) begin
              r.status  = STATUS_DROPPED;
              r.dropped = 1'b1;
            end
          end
        end
        FUNC_OPEN: begin
          if (hit >= 0 && !slot_dropped[hit]) begin
            r.status = STATUS_EXISTS;
            r.slot   = hit[SLOT_OUT_W-1:0];
            r.dir_in = fwd;
          end else begin
            // A dropped match is reused in place, otherwise the lowest free slot.
            for (int i = 0; i < CONN_SLOTS && hit < 0; i++)
              if (!slot_live[i]) hit = i;
            if (hit < 0) begin
              r.status = STATUS_FULL;
            end else begin
              slot_live[hit]    = 1'b1;
              slot_dropped[hit] = 1'b0;
              slot_key[hit]     = pkt;
              r.slot            = hit[SLOT_OUT_W-1:0];
              r.dir_in          = 1'b1;
            end
          end
        end
        default: begin
          r.slot = hdl;
          if (int'(hdl) >= CONN_SLOTS || !slot_live[hdl]) begin
            r.status = STATUS_BAD_HANDLE;
          end else if (op == FUNC_CLOSE) begin
            slot_live[hdl]    = 1'b0;
            slot_dropped[hdl] = 1'b0;
          end else begin
            slot_dropped[hdl] = 1'b1;
          end
        end
      endcase
      expected_replies.push_back(r);
    endfunction

    function void check_reply(logic [STATUS_W-1:0] st, logic [SLOT_OUT_W-1:0] sl,
                              logic di, logic wd);
      conn_reply_t exp;
      if (expected_replies.size() == 0) begin
        $error("reply with no request outstanding: status %0d slot %0d", st, sl);
        errors++;
        return;
      end
      exp = expected_replies.pop_front();
      if (int'(exp.status) < 6) status_seen[exp.status]++;
      if (st !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, st);
        errors++;
      end
      if (sl !== exp.slot) begin
        $error("slot: expected %0d, got %0d", exp.slot, sl);
        errors++;
      end
      if (di !== exp.dir_in) begin
        $error("forward: expected %0d, got %0d", exp.dir_in, di);
        errors++;
      end
      if (wd !== exp.dropped) begin
        $error("was_dropped: expected %0d, got %0d", exp.dropped, wd);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [FUNC_W-1:0]     func = '0;
  logic [IP_W-1:0]       src_ip = '0;
  logic [IP_W-1:0]       dst_ip = '0;
  logic [PORT_W-1:0]     src_port = '0;
  logic [PORT_W-1:0]     dst_port = '0;
  logic [HANDLE_W-1:0]   handle = '0;
  logic                  done;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_OUT_W-1:0] slot;
  logic                  forward;
  logic                  was_dropped;

  conn_ledger ledger = new();
  tuple_t     tuple_pool[$];
  int         idle_cycles = 0;
  bit         burst_mode = 1'b0;

  tcp_connection_table DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .src_ip       (src_ip),
    .dst_ip       (dst_ip),
    .src_port     (src_port),
    .dst_port     (dst_port),
    .handle       (handle),
    .done         (done),
    .status       (status),
    .slot         (slot),
    .forward      (forward),
    .was_dropped  (was_dropped)
  );

  // Free-running clock with a period of 8 ns.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Monitor. Both the request handshake and the reply strobe are sampled at
  // the rising edge, before any of that edge's nonblocking updates land, so
  // the testbench and the block agree on what was accepted. A request noted
  // here updates the ledger at once, which matches the block's own order of
  // execution, since it finishes one request before it takes the next.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        ledger.note_request(func_t'(func), {src_ip, dst_ip, src_port, dst_port}, handle);
      if (done)
        ledger.check_reply(status, slot, forward, was_dropped);
    end
  end

  // The watchdog counts cycles in which no request was accepted.
  always @(posedge clk) begin
    if (rst || (start && !busy))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("timeout: no request accepted for %0d cycles", IDLE_LIMIT);
    $display("testbench failed");
    $finish;
  end

  // Presents one request and holds it until the block takes it. With a gap of
  // zero, start stays high and the next call puts its request straight on the
  // ports in the same time step, so a stale request is never taken twice.
  // During a gap the payload ports carry noise, which the block must ignore.
  task automatic send_request(input func_t op, input tuple_t pkt,
                              input logic [HANDLE_W-1:0] hdl, input int gap);
    start    <= 1'b1;
    func     <= op;
    src_ip   <= pkt.src_ip;
    dst_ip   <= pkt.dst_ip;
    src_port <= pkt.src_port;
    dst_port <= pkt.dst_port;
    handle   <= hdl;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start    <= 1'b0;
      func     <= FUNC_W'($urandom_range(3));
      src_ip   <= $urandom;
      dst_ip   <= $urandom;
      src_port <= PORT_W'($urandom_range(16'hFFFF));
      dst_port <= PORT_W'($urandom_range(16'hFFFF));
      handle   <= HANDLE_W'($urandom_range(63));
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lowers start and waits until every outstanding reply has been checked.
  // The first edge is always waited for, so that the monitor has noted the
  // request that was taken in this very time step.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (ledger.expected_replies.size() != 0);
  endtask

  // Mostly short gaps, now and then a long one; none at all in burst mode.
  function automatic int random_gap();
    int r;
    r = $urandom_range(99);
    if (burst_mode || r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  // A quarter of new tuples come from a tiny value space, so that symmetric
  // tuples (equal in both orientations) and near misses turn up often.
  function automatic tuple_t random_tuple();
    tuple_t t;
    if ($urandom_range(3) == 0) begin
      t.src_ip   = $urandom_range(2);
      t.dst_ip   = $urandom_range(2);
      t.src_port = PORT_W'($urandom_range(2));
      t.dst_port = PORT_W'($urandom_range(2));
    end else begin
      t.src_ip   = $urandom;
      t.dst_ip   = $urandom;
      t.src_port = PORT_W'($urandom_range(16'hFFFF));
      t.dst_port = PORT_W'($urandom_range(16'hFFFF));
    end
    return t;
  endfunction

  // Open and lookup mostly reuse tuples seen before, in either orientation,
  // so that matches, dropped matches and reopening are exercised heavily.
  function automatic tuple_t pick_tuple(input bit for_open);
    tuple_t t;
    if (tuple_pool.size() != 0 && $urandom_range(99) < 60) begin
      t = tuple_pool[$urandom_range(tuple_pool.size() - 1)];
      if ($urandom_range(1)) t = conn_ledger::swap_ends(t);
    end else begin
      t = random_tuple();
      if (for_open) begin
        tuple_pool.push_back(t);
        if (tuple_pool.size() > POOL_DEPTH) void'(tuple_pool.pop_front());
      end
    end
    return t;
  endfunction

  // Three handles in four point at a slot that the ledger believes is live, if any is;
  // the rest are arbitrary and often free, which gives the bad handle case.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    logic [HANDLE_W-1:0] h;
    int                  first;
    bit                  found;
    h     = HANDLE_W'($urandom_range(63));
    first = int'(h);
    found = 1'b0;
    if ($urandom_range(3) != 0) begin
      for (int k = 0; k < CONN_SLOTS && !found; k++) begin
        if (ledger.slot_live[(first + k) % CONN_SLOTS]) begin
          h     = HANDLE_W'((first + k) % CONN_SLOTS);
          found = 1'b1;
        end
      end
    end
    return h;
  endfunction

  // One random phase. The weights are percentages for open, lookup and
  // close; drop takes what is left. Runs of back-to-back requests come and
  // go at random. The phase ends by draining every outstanding reply.
  task automatic run_phase(input int items, input int w_open, input int w_lookup,
                           input int w_close);
    int     r;
    func_t  op;
    tuple_t pkt;
    for (int n = 0; n < items; n++) begin
      if (n % 50 == 0) burst_mode = ($urandom_range(2) == 0);
      r = $urandom_range(99);
      if (r < w_open)                           op = FUNC_OPEN;
      else if (r < w_open + w_lookup)           op = FUNC_LOOKUP;
      else if (r < w_open + w_lookup + w_close) op = FUNC_CLOSE;
      else                                      op = FUNC_DROP;
      if (op == FUNC_OPEN || op == FUNC_LOOKUP)
        pkt = pick_tuple(op == FUNC_OPEN);
      else
        pkt = random_tuple();
      send_request(op, pkt, pick_handle(), random_gap());
    end
    burst_mode = 1'b0;
    drain();
  endtask

  initial begin
    tuple_t all_ones;
    tuple_t all_zero;
    tuple_t conn_a;
    tuple_t conn_a_rev;
    all_ones   = '1;
    all_zero   = '0;
    conn_a     = {32'h0A00_0001, 32'hC0A8_0001, 16'd1234, 16'd80};
    conn_a_rev = conn_ledger::swap_ends(conn_a);

    // Reset is held high from the start, then lowered and never raised again.
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The table is empty: nothing is found and no handle is good.
    send_request(FUNC_LOOKUP, all_zero, 6'd0,  0);
    send_request(FUNC_CLOSE,  all_ones, 6'd0,  1);
    send_request(FUNC_DROP,   all_zero, 6'd63, 0);
    // Fill the three lowest slots, the extreme tuples first.
    send_request(FUNC_OPEN,   all_ones, 6'd0,  0);
    send_request(FUNC_OPEN,   all_zero, 6'd0,  2);
    send_request(FUNC_OPEN,   conn_a,   6'd0,  0);
    // A live connection is already there, in either orientation.
    send_request(FUNC_OPEN,   conn_a,     6'd0, 0);
    send_request(FUNC_OPEN,   conn_a_rev, 6'd0, 1);
    send_request(FUNC_LOOKUP, conn_a,     6'd0, 0);
    send_request(FUNC_LOOKUP, conn_a_rev, 6'd0, 0);
    // Dropping twice leaves the entry dropped; lookup reports the mark.
    send_request(FUNC_DROP,   all_zero,   6'd2, 0);
    send_request(FUNC_DROP,   all_ones,   6'd2, 3);
    send_request(FUNC_LOOKUP, conn_a_rev, 6'd0, 0);
    // Opening a dropped connection reversed replaces it in packet orientation.
    send_request(FUNC_OPEN,   conn_a_rev, 6'd0, 0);
    send_request(FUNC_LOOKUP, conn_a,     6'd0, 0);
    // Close frees the slot; a second close finds a free slot.
    send_request(FUNC_CLOSE,  all_zero,   6'd2, 0);
    send_request(FUNC_CLOSE,  all_zero,   6'd2, 0);
    // The freed slot is the lowest free one again; closing a dropped entry works.
    send_request(FUNC_OPEN,   conn_a,     6'd0, 1);
    send_request(FUNC_DROP,   all_zero,   6'd2, 0);
    send_request(FUNC_CLOSE,  all_ones,   6'd2, 0);
    // A symmetric tuple matches forwards first.
    send_request(FUNC_LOOKUP, all_ones,   6'd0, 0);
    send_request(FUNC_CLOSE,  all_zero,   6'd63, 0);
    drain();

    // Random part. The fill phase drives the table full and keeps it there;
    // the drop phase reopens dropped connections while it is full; the close
    // phase empties it again, and the last phase mixes everything.
    run_phase(PHASE_ITEMS, 80, 10, 5);
    run_phase(PHASE_ITEMS, 35, 25, 5);
    run_phase(PHASE_ITEMS, 20, 20, 50);
    run_phase(PHASE_ITEMS, 30, 30, 20);

    // Every reply has been checked by now; the wait below still catches strays.
    repeat (4) @(posedge clk);
    $display("Covered %0d requests; replies by status: ok %0d, exists %0d, full %0d,",
             ledger.requests, ledger.status_seen[STATUS_OK],
             ledger.status_seen[STATUS_EXISTS], ledger.status_seen[STATUS_FULL]);
    $display("  not found %0d, dropped %0d, bad handle %0d; %0d mismatches.",
             ledger.status_seen[STATUS_NOT_FOUND], ledger.status_seen[STATUS_DROPPED],
             ledger.status_seen[STATUS_BAD_HANDLE], ledger.errors);
    if (ledger.errors == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
